// File: design/memory_slot_type_classifier_top_defines.svh
// Assertion macros used by the memory slot type classifier top level.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MEMORY_SLOT_TYPE_CLASSIFIER_TOP_DEFINES_SVH
`define MEMORY_SLOT_TYPE_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication.
`define MSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/msc_pkg.sv
// Package for the memory slot type classifier: codes, constants and the
// item structs passed between the top level and the range lookup.
`timescale 1ns / 1ps

package msc_pkg;

    localparam int RANGE_ENTRIES_DEFAULT = 16;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    localparam logic [3:0] WIDTH_QWORD = 4'd8;
    localparam logic [3:0] WIDTH_DWORD = 4'd4;

    localparam logic [63:0] LOW_GUARD    = 64'h0000_0000_0001_0000;
    localparam logic [30:0] F32_MIN_BITS = 31'h3586_37BD;
    localparam logic [30:0] F32_MAX_BITS = 31'h4E6E_6B28;
    localparam logic [62:0] F64_MIN_BITS = 63'h3EB0_C6F7_A0B5_ED8D;
    localparam logic [62:0] F64_MAX_BITS = 63'h41CD_CD65_0000_0000;

    typedef enum logic [2:0] {
        TYPE_BYTES  = 3'd0,
        TYPE_UINT32 = 3'd1,
        TYPE_UINT64 = 3'd2,
        TYPE_INT32  = 3'd3,
        TYPE_INT64  = 3'd4,
        TYPE_FLOAT  = 3'd5,
        TYPE_DOUBLE = 3'd6
    } msc_type_t;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic [3:0]  width;
        logic [63:0] value;
        logic        ovf;
    } msc_item_t;

    typedef struct packed {
        msc_item_t item;
        logic      hit;
        logic      real_ok;
    } msc_lookup_t;

endpackage

// File: design/msc_range_lookup.sv
// Range lookup pipeline: per-entry base compares, then a registered
// max-base tree, plus the float/double magnitude test. Uses msc_pkg.
`timescale 1ns / 1ps

module msc_range_lookup #(
    parameter int ENTRIES = msc_pkg::RANGE_ENTRIES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  msc_pkg::msc_item_t               item,
    input  logic [$clog2(ENTRIES + 1) - 1:0] count,
    input  logic [63:0]                      base [ENTRIES],
    input  logic [63:0]                      limit [ENTRIES],
    output msc_pkg::msc_lookup_t             result
);

    localparam int CW     = $clog2(ENTRIES + 1);
    localparam int LEVELS = (ENTRIES > 1) ? $clog2(ENTRIES) : 0;
    localparam int PAD    = 1 << LEVELS;

    function automatic logic float_plausible(input logic [63:0] v);
        logic [30:0] m;
        m = v[30:0];
        if (m[30:23] == 8'hFF || m == 31'd0)
            return 1'b0;
        return (m >= msc_pkg::F32_MIN_BITS) && (m <= msc_pkg::F32_MAX_BITS);
    endfunction

    function automatic logic double_plausible(input logic [63:0] v);
        logic [62:0] m;
        m = v[62:0];
        if (m[62:52] == 11'h7FF || m == 63'd0)
            return 1'b0;
        return (m >= msc_pkg::F64_MIN_BITS) && (m <= msc_pkg::F64_MAX_BITS);
    endfunction

    logic               node_vld_reg  [LEVELS + 1][PAD];
    logic [63:0]        node_base_reg [LEVELS + 1][PAD];
    logic [63:0]        node_lim_reg  [LEVELS + 1][PAD];
    msc_pkg::msc_item_t item_pipe_reg [LEVELS + 1];
    logic               real_pipe_reg [LEVELS + 1];
    logic               real_next;

    always_comb
    begin
        if (item.width == msc_pkg::WIDTH_QWORD)
            real_next = double_plausible(item.value);
        else if (item.width == msc_pkg::WIDTH_DWORD)
            real_next = float_plausible(item.value);
        else
            real_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_pipe_reg[0] <= '0;
            real_pipe_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            item_pipe_reg[0] <= item;
            real_pipe_reg[0] <= real_next;
        end
    end

    // leaf stage: entry is a candidate when loaded and its base is not above the address
    for (genvar i = 0; i < PAD; i++)
    begin : g_leaf
        if (i < ENTRIES)
        begin : g_used
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    node_vld_reg[0][i] <= 1'b0;
                else if (en)
                    node_vld_reg[0][i] <= (CW'(i) < count) && (base[i] <= item.value);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    node_base_reg[0][i] <= base[i];
                    node_lim_reg[0][i]  <= limit[i];
                end
            end
        end
        else
        begin : g_pad
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    node_vld_reg[0][i] <= 1'b0;
                else if (en)
                    node_vld_reg[0][i] <= 1'b0;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    node_base_reg[0][i] <= '0;
                    node_lim_reg[0][i]  <= '0;
                end
            end
        end
    end

    // reduction: keep larger base, larger limit on equal bases
    for (genvar l = 1; l <= LEVELS; l++)
    begin : g_level
        for (genvar j = 0; j < (PAD >> l); j++)
        begin : g_node
            logic take_a;

            assign take_a = node_vld_reg[l - 1][2 * j] &&
                            (!node_vld_reg[l - 1][2 * j + 1] ||
                             (node_base_reg[l - 1][2 * j] > node_base_reg[l - 1][2 * j + 1]) ||
                             ((node_base_reg[l - 1][2 * j] == node_base_reg[l - 1][2 * j + 1]) &&
                              (node_lim_reg[l - 1][2 * j] >= node_lim_reg[l - 1][2 * j + 1])));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    node_vld_reg[l][j] <= 1'b0;
                else if (en)
                    node_vld_reg[l][j] <= node_vld_reg[l - 1][2 * j] ||
                                          node_vld_reg[l - 1][2 * j + 1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    node_base_reg[l][j] <= take_a ? node_base_reg[l - 1][2 * j]
                                                  : node_base_reg[l - 1][2 * j + 1];
                    node_lim_reg[l][j]  <= take_a ? node_lim_reg[l - 1][2 * j]
                                                  : node_lim_reg[l - 1][2 * j + 1];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                item_pipe_reg[l] <= '0;
                real_pipe_reg[l] <= 1'b0;
            end
            else if (en)
            begin
                item_pipe_reg[l] <= item_pipe_reg[l - 1];
                real_pipe_reg[l] <= real_pipe_reg[l - 1];
            end
        end
    end

    always_comb
    begin
        result.item    = item_pipe_reg[LEVELS];
        result.real_ok = real_pipe_reg[LEVELS];
        result.hit     = node_vld_reg[LEVELS][0] &&
                         (item_pipe_reg[LEVELS].value < node_lim_reg[LEVELS][0]) &&
                         (item_pipe_reg[LEVELS].value >= msc_pkg::LOW_GUARD);
    end

endmodule

// File: design/memory_slot_type_classifier_top.sv
// Top level of the memory slot type classifier: region table, run state
// and output register. Uses msc_pkg, msc_range_lookup and the defines header.
//
// Usage:
//   Input stream (s_axis): tuser carries the opcode (clear table, add region,
//   sample). tdata carries sample value / region base, region end and the
//   sample width; tlast marks the last sample of a slot's run.
//   Output stream (m_axis): one request per run, issued for its last sample,
//   carrying the type code and the sticky region overflow flag.
//   Config channel (cfg_valid/cfg_data): pointer width select, always ready;
//   write it only while no run is in flight.
// Timing:
//   One input request per cycle while not stalled. Clear and add take effect
//   at acceptance. A sample passes through the input register, the lookup's
//   leaf stage and its registered max-base tree over the region table, then
//   the output register.
// Reset: table empty, overflow clear, no run open, pointer width 8 bytes.
// Stall: when the output register holds a request that is not taken, the
//   whole pipeline holds and s_axis_tready drops until it is taken.
`timescale 1ns / 1ps
`include "memory_slot_type_classifier_top_defines.svh"

module memory_slot_type_classifier_top #(
    parameter int RANGE_ENTRIES = msc_pkg::RANGE_ENTRIES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sample_value[63:0], region_end[127:64], sample_bytes[131:128], zero pad
    input  logic [135:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // type_code[2:0], region_overflow[3], zero pad
    output logic [7:0]   m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data
);

    localparam int CW = $clog2(RANGE_ENTRIES + 1);
    localparam int IW = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;

    logic [63:0]          base_reg  [RANGE_ENTRIES];
    logic [63:0]          limit_reg [RANGE_ENTRIES];
    logic [CW-1:0]        count_reg;
    logic                 overflow_reg;
    logic                 ptr8_reg;

    msc_pkg::msc_item_t   item_reg;
    msc_pkg::msc_item_t   item_next;
    msc_pkg::msc_lookup_t lk;

    logic [3:0]           run_width_reg;
    logic                 run_open_reg;
    logic                 differs_reg;
    logic                 pok_reg, pseen_reg, rok_reg, rseen_reg;

    logic [3:0]           width_next;
    logic                 differs_next;
    logic                 pok_next, pseen_next, rok_next, rseen_next;
    msc_pkg::msc_type_t   code_next;

    logic                 out_valid_reg;
    msc_pkg::msc_type_t   out_code_reg;
    logic                 out_ovf_reg;

    logic                 en;
    logic                 accept;
    logic                 table_full;
    logic [63:0]          sval;
    logic [63:0]          rend;
    logic [3:0]           sbytes;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;
    assign cfg_ready     = 1'b1;
    assign sval          = s_axis_tdata[63:0];
    assign rend          = s_axis_tdata[127:64];
    assign sbytes        = s_axis_tdata[131:128];
    assign table_full    = (count_reg >= CW'(RANGE_ENTRIES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptr8_reg <= 1'b1;
        else if (cfg_valid)
            ptr8_reg <= cfg_data;
    end

    // region table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (accept)
        begin
            case (s_axis_tuser)
                msc_pkg::OP_CLEAR:
                begin
                    count_reg    <= '0;
                    overflow_reg <= 1'b0;
                end
                msc_pkg::OP_ADD:
                begin
                    if (table_full)
                        overflow_reg <= 1'b1;
                    else
                        count_reg <= count_reg + CW'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tuser == msc_pkg::OP_ADD && !table_full)
        begin
            base_reg[count_reg[IW-1:0]]  <= sval;
            limit_reg[count_reg[IW-1:0]] <= rend;
        end
    end

    // input register: bytes beyond the width are dropped here
    always_comb
    begin
        item_next.valid = accept && (s_axis_tuser == msc_pkg::OP_SAMPLE);
        item_next.last  = s_axis_tlast;
        item_next.width = sbytes;
        item_next.ovf   = overflow_reg;
        for (int k = 0; k < 8; k++)
            item_next.value[8*k +: 8] = (sbytes > 4'(k)) ? sval[8*k +: 8] : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_reg <= '0;
        else if (en)
            item_reg <= item_next;
    end

    msc_range_lookup #(
        .ENTRIES (RANGE_ENTRIES)
    ) u_lookup (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .item   (item_reg),
        .count  (count_reg),
        .base   (base_reg),
        .limit  (limit_reg),
        .result (lk)
    );

    // run accumulation and classification
    always_comb
    begin
        if (!run_open_reg)
        begin
            width_next   = lk.item.width;
            differs_next = 1'b0;
            pok_next     = 1'b1;
            pseen_next   = 1'b0;
            rok_next     = 1'b1;
            rseen_next   = 1'b0;
        end
        else
        begin
            width_next   = run_width_reg;
            differs_next = differs_reg || (lk.item.width != run_width_reg);
            pok_next     = pok_reg;
            pseen_next   = pseen_reg;
            rok_next     = rok_reg;
            rseen_next   = rseen_reg;
        end

        if (|lk.item.value)
        begin
            if (lk.hit)
                pseen_next = 1'b1;
            else
                pok_next = 1'b0;
            if (lk.real_ok)
                rseen_next = 1'b1;
            else
                rok_next = 1'b0;
        end

        if (differs_next)
            code_next = msc_pkg::TYPE_BYTES;
        else if (width_next == (ptr8_reg ? msc_pkg::WIDTH_QWORD : msc_pkg::WIDTH_DWORD) &&
                 pok_next && pseen_next)
            code_next = ptr8_reg ? msc_pkg::TYPE_UINT64 : msc_pkg::TYPE_UINT32;
        else if (width_next == msc_pkg::WIDTH_QWORD)
            code_next = (rok_next && rseen_next) ? msc_pkg::TYPE_DOUBLE : msc_pkg::TYPE_INT64;
        else if (width_next == msc_pkg::WIDTH_DWORD)
            code_next = (rok_next && rseen_next) ? msc_pkg::TYPE_FLOAT : msc_pkg::TYPE_INT32;
        else
            code_next = msc_pkg::TYPE_BYTES;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_width_reg <= '0;
            run_open_reg  <= 1'b0;
            differs_reg   <= 1'b0;
            pok_reg       <= 1'b1;
            pseen_reg     <= 1'b0;
            rok_reg       <= 1'b1;
            rseen_reg     <= 1'b0;
        end
        else if (en && lk.item.valid)
        begin
            run_width_reg <= width_next;
            run_open_reg  <= !lk.item.last;
            differs_reg   <= differs_next;
            pok_reg       <= pok_next;
            pseen_reg     <= pseen_next;
            rok_reg       <= rok_next;
            rseen_reg     <= rseen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= lk.item.valid && lk.item.last;
    end

    always_ff @(posedge clk)
    begin
        if (en && lk.item.valid && lk.item.last)
        begin
            out_code_reg <= code_next;
            out_ovf_reg  <= lk.item.ovf;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_ovf_reg, out_code_reg};

    `MSC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(RANGE_ENTRIES),
        "region count beyond table size")

    `MSC_ASSERT_NEXT(a_full_sets_ovf,
        accept && s_axis_tuser == msc_pkg::OP_ADD && table_full,
        overflow_reg && count_reg == CW'(RANGE_ENTRIES),
        "add to full table did not set overflow")

    `MSC_ASSERT_NEXT(a_clear_empties,
        accept && s_axis_tuser == msc_pkg::OP_CLEAR,
        !overflow_reg && count_reg == '0,
        "clear did not empty the region table")

    `MSC_ASSERT_NEXT(a_mixed_is_bytes,
        en && lk.item.valid && lk.item.last && differs_next,
        out_valid_reg && out_code_reg == msc_pkg::TYPE_BYTES,
        "mixed-width run not classified as bytes")

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for memory_slot_type_classifier_top: loads region tables, streams slot
// sample runs under random gaps and stalls, and checks every type code request.
// Depends on msc_pkg and the classifier RTL; needs no other files.

module tb_top;

    localparam int TABLE_DEPTH = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam logic [63:0] ADDR_FLOOR = 64'h0000_0000_0001_0000;
    localparam logic [30:0] SGL_LO = 31'h3586_37BD;
    localparam logic [30:0] SGL_HI = 31'h4E6E_6B28;
    localparam logic [62:0] DBL_LO = 63'h3EB0_C6F7_A0B5_ED8D;
    localparam logic [62:0] DBL_HI = 63'h41CD_CD65_0000_0000;

    typedef struct packed {
        msc_pkg::msc_type_t kind;
        logic               ovf;
    } slot_verdict_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // sample_value[63:0], region_end[127:64], sample_bytes[131:128], zero pad
    logic [135:0] s_axis_tdata = '0;
    // opcode[1:0]
    logic [1:0]   s_axis_tuser = '0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // type_code[2:0], region_overflow[3], zero pad
    logic [7:0]   m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_data = 1'b0;

    // predicted block state
    logic [63:0] tbl_base [TABLE_DEPTH];
    logic [63:0] tbl_limit [TABLE_DEPTH];
    int          tbl_count = 0;
    logic        tbl_overflow = 1'b0;
    logic        run_active = 1'b0;
    logic [3:0]  cur_width = '0;
    logic        mixed_width = 1'b0;
    logic        all_ptr = 1'b1;
    logic        any_ptr = 1'b0;
    logic        all_real = 1'b1;
    logic        any_real = 1'b0;
    logic        ptr_eight = 1'b1;

    slot_verdict_t verdicts_due [$];
    int fail_count = 0;
    int sent_items = 0;
    int send_calm = 0;
    int rcv_calm = 0;
    int rcv_stall = 0;
    int quiet_cycles = 0;

    memory_slot_type_classifier_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit region_hit(logic [63:0] addr);
        bit          found;
        logic [63:0] best_b;
        logic [63:0] best_l;
        int          i;
        found = 1'b0;
        best_b = '0;
        best_l = '0;
        if (addr < ADDR_FLOOR)
            return 1'b0;
        for (i = 0; i < tbl_count; i++)
        begin
            if (tbl_base[i] > addr)
                continue;
            if (!found || tbl_base[i] > best_b ||
                (tbl_base[i] == best_b && tbl_limit[i] > best_l))
            begin
                found = 1'b1;
                best_b = tbl_base[i];
                best_l = tbl_limit[i];
            end
        end
        return found && addr < best_l;
    endfunction

    function automatic bit single_in_band(logic [63:0] v);
        logic [30:0] m;
        m = v[30:0];
        if (m[30:23] == 8'hFF || m == '0)
            return 1'b0;
        return m >= SGL_LO && m <= SGL_HI;
    endfunction

    function automatic bit double_in_band(logic [63:0] v);
        logic [62:0] m;
        m = v[62:0];
        if (m[62:52] == 11'h7FF || m == '0)
            return 1'b0;
        return m >= DBL_LO && m <= DBL_HI;
    endfunction

    // Track one accepted request; a run's last sample queues its type code.
    function automatic void classify_request(logic [1:0] op, logic [63:0] val,
                                             logic [63:0] rend, logic [3:0] w,
                                             logic last);
        logic [63:0]   v;
        logic [3:0]    pw;
        slot_verdict_t verdict;
        case (op)
            msc_pkg::OP_CLEAR:
            begin
                tbl_count = 0;
                tbl_overflow = 1'b0;
            end
            msc_pkg::OP_ADD:
            begin
                if (tbl_count < TABLE_DEPTH)
                begin
                    tbl_base[tbl_count] = val;
                    tbl_limit[tbl_count] = rend;
                    tbl_count++;
                end
                else
                    tbl_overflow = 1'b1;
            end
            msc_pkg::OP_SAMPLE:
            begin
                if (w == 4'd0)
                    v = '0;
                else if (w >= 4'd8)
                    v = val;
                else
                    v = val & ((64'd1 << (8 * w)) - 64'd1);
                if (!run_active)
                begin
                    run_active = 1'b1;
                    cur_width = w;
                    mixed_width = 1'b0;
                    all_ptr = 1'b1;
                    any_ptr = 1'b0;
                    all_real = 1'b1;
                    any_real = 1'b0;
                end
                else if (w != cur_width)
                    mixed_width = 1'b1;
                if (v != '0)
                begin
                    if (region_hit(v))
                        any_ptr = 1'b1;
                    else
                        all_ptr = 1'b0;
                    if ((w == 4'd8 && double_in_band(v)) || (w == 4'd4 && single_in_band(v)))
                        any_real = 1'b1;
                    else
                        all_real = 1'b0;
                end
                if (last)
                begin
                    pw = ptr_eight ? 4'd8 : 4'd4;
                    if (mixed_width)
                        verdict.kind = msc_pkg::TYPE_BYTES;
                    else if (cur_width == pw && all_ptr && any_ptr)
                        verdict.kind = ptr_eight ? msc_pkg::TYPE_UINT64
                                                 : msc_pkg::TYPE_UINT32;
                    else if (cur_width == 4'd8)
                        verdict.kind = (all_real && any_real) ? msc_pkg::TYPE_DOUBLE
                                                              : msc_pkg::TYPE_INT64;
                    else if (cur_width == 4'd4)
                        verdict.kind = (all_real && any_real) ? msc_pkg::TYPE_FLOAT
                                                              : msc_pkg::TYPE_INT32;
                    else
                        verdict.kind = msc_pkg::TYPE_BYTES;
                    verdict.ovf = tbl_overflow;
                    verdicts_due.insert(verdicts_due.size(), verdict);
                    run_active = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [63:0] val,
                                input logic [63:0] rend, input logic [3:0] w,
                                input logic last);
        int gap;
        gap = (send_calm > 0) ? 0 : draw_gap();
        if (send_calm > 0)
            send_calm--;
        else if ($urandom_range(0, 99) == 0)
            send_calm = $urandom_range(30, 200);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tdata <= {4'h0, w, rend, val};
        s_axis_tuser <= op;
        s_axis_tlast <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        classify_request(op, val, rend, w, last);
        if (op != OP_IGNORED)
            sent_items++;
    endtask

    // Wait for all results plus the pipeline depth so nothing is in flight.
    task automatic settle_block();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_pointer_width(input logic eight);
        settle_block();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= eight;
        do @(posedge clk); while (!cfg_ready);
        ptr_eight = eight;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] real_bits(bit dbl);
        logic [63:0] r;
        logic [62:0] dm;
        logic [30:0] sm;
        logic        sgn;
        r = {$urandom, $urandom};
        sgn = r[63];
        if (dbl)
        begin
            case ($urandom_range(0, 15))
                0: dm = DBL_LO;
                1: dm = DBL_HI;
                2: dm = DBL_LO - 63'd1;
                3: dm = DBL_HI + 63'd1;
                4: dm = {11'h7FF, 52'd0};
                5: dm = {11'h7FF, 1'b1, r[50:0]};
                6: dm = '0;
                7: dm = 63'd1;
                default:
                begin
                    dm = {11'($urandom_range(11'h3EB, 11'h41C)), r[51:0]};
                    if (dm < DBL_LO)
                        dm = DBL_LO;
                    if (dm > DBL_HI)
                        dm = DBL_HI;
                end
            endcase
            return {sgn, dm};
        end
        case ($urandom_range(0, 15))
            0: sm = SGL_LO;
            1: sm = SGL_HI;
            2: sm = SGL_LO - 31'd1;
            3: sm = SGL_HI + 31'd1;
            4: sm = {8'hFF, 23'd0};
            5: sm = {8'hFF, 1'b1, r[21:0]};
            6: sm = '0;
            7: sm = 31'd1;
            default:
            begin
                sm = {8'($urandom_range(8'h6B, 8'h9C)), r[22:0]};
                if (sm < SGL_LO)
                    sm = SGL_LO;
                if (sm > SGL_HI)
                    sm = SGL_HI;
            end
        endcase
        return {r[62:31], sgn, sm};
    endfunction

    function automatic logic [63:0] pointer_bits();
        logic [63:0] r;
        logic [63:0] span;
        int          i;
        r = {$urandom, $urandom};
        if (tbl_count == 0 || $urandom_range(0, 4) == 0)
            return ptr_eight ? r : {32'h0, r[31:0]};
        i = $urandom_range(0, tbl_count - 1);
        span = tbl_limit[i] - tbl_base[i];
        case ($urandom_range(0, 7))
            0: return tbl_base[i];
            1: return tbl_limit[i];
            2: return tbl_limit[i] - 64'd1;
            3: return tbl_base[i] - 64'd1;
            default:
                return (tbl_limit[i] > tbl_base[i]) ? tbl_base[i] + r % span : tbl_base[i];
        endcase
    endfunction

    // Mostly a clear and a fresh table; sometimes enough adds to overflow it.
    task automatic load_table();
        int          n;
        int          r;
        int          j;
        bit          narrow;
        logic [63:0] b;
        logic [63:0] l;
        narrow = !ptr_eight ^ ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) != 0)
            send_request(msc_pkg::OP_CLEAR, {$urandom, $urandom}, {$urandom, $urandom},
                         4'($urandom), 1'($urandom));
        r = $urandom_range(0, 99);
        if (r < 70)
            n = $urandom_range(1, 8);
        else if (r < 85)
            n = $urandom_range(9, 16);
        else
            n = $urandom_range(17, 22);
        for (j = 0; j < n; j++)
        begin
            case ($urandom_range(0, 9))
                0: b = 64'($urandom_range(0, 32'h0002_0000));
                1: b = (tbl_count > 0) ? tbl_base[$urandom_range(0, tbl_count - 1)]
                                       : ADDR_FLOOR;
                default: b = narrow ? {32'h0, $urandom} : {$urandom, $urandom};
            endcase
            l = b + 64'($urandom_range(1, 32'h0010_0000));
            if ($urandom_range(0, 9) == 0)
                l = b - 64'($urandom_range(0, 16));
            send_request(msc_pkg::OP_ADD, b, l, 4'($urandom), 1'($urandom));
        end
    endtask

    task automatic slot_run();
        int          style;
        int          len;
        int          k;
        int          r;
        logic [3:0]  w;
        logic [3:0]  ws;
        logic [63:0] val;
        logic [63:0] keep;
        style = $urandom_range(0, 9);
        if (style < 4)
            w = ptr_eight ? 4'd8 : 4'd4;
        else if (style < 7)
            w = ($urandom_range(0, 1) != 0) ? 4'd8 : 4'd4;
        else
            w = 4'($urandom_range(0, 15));
        len = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 16);
        for (k = 0; k < len; k++)
        begin
            // table traffic or an ignored opcode in the middle of a run
            if ($urandom_range(0, 39) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: send_request(msc_pkg::OP_ADD, pointer_bits(), {$urandom, $urandom},
                                    4'($urandom), 1'($urandom));
                    1: send_request(msc_pkg::OP_CLEAR, '0, '0, 4'($urandom), 1'($urandom));
                    default: send_request(OP_IGNORED, {$urandom, $urandom},
                                          {$urandom, $urandom}, 4'($urandom), 1'($urandom));
                endcase
            end
            ws = ($urandom_range(0, 29) == 0) ? 4'($urandom_range(0, 15)) : w;
            r = $urandom_range(0, 9);
            if (r < 2)
                val = '0;
            else if (r < 8 && style < 4)
                val = pointer_bits();
            else if (r < 8 && style < 7)
                val = real_bits(ws == 4'd8);
            else
                val = {$urandom, $urandom};
            if (ws > 4'd0 && ws < 4'd8)
            begin
                keep = (64'd1 << (8 * ws)) - 64'd1;
                val = (val & keep) | ({$urandom, $urandom} & ~keep);
            end
            send_request(msc_pkg::OP_SAMPLE, val, {$urandom, $urandom}, ws, k == len - 1);
        end
    endtask

    task automatic run_phase(input int n);
        int start;
        start = sent_items;
        load_table();
        while (sent_items - start < n)
        begin
            if ($urandom_range(0, 5) == 0)
                load_table();
            slot_run();
        end
    endtask

    task automatic test_directed_cases();
        send_request(msc_pkg::OP_CLEAR, '0, '0, 4'd0, 1'b0);
        send_request(msc_pkg::OP_ADD, 64'h0000_0001_0000_0000, 64'h0000_0001_0000_1000,
                     4'd0, 1'b0);
        send_request(msc_pkg::OP_ADD, 64'h2_0000, 64'h3_0000, 4'd0, 1'b0);
        send_request(msc_pkg::OP_ADD, 64'h8000, 64'h4_0000, 4'd0, 1'b0);
        send_request(msc_pkg::OP_ADD, 64'h2_0000, 64'h2_8000, 4'd0, 1'b0);
        // zero plus an in-range pointer
        send_request(msc_pkg::OP_SAMPLE, '0, '0, 4'd8, 1'b0);
        send_request(msc_pkg::OP_SAMPLE, 64'h0000_0001_0000_0800, '0, 4'd8, 1'b1);
        // equal bases take the larger limit; higher base shadows the wide range
        send_request(msc_pkg::OP_SAMPLE, 64'h2_C000, '0, 4'd8, 1'b0);
        send_request(msc_pkg::OP_SAMPLE, 64'h3_5000, '0, 4'd8, 1'b1);
        send_request(msc_pkg::OP_SAMPLE, 64'hFFFF, '0, 4'd8, 1'b1);
        send_request(msc_pkg::OP_SAMPLE, 64'h3FF0_0000_0000_0000, '0, 4'd8, 1'b0);
        send_request(msc_pkg::OP_SAMPLE, 64'hC1CD_CD65_0000_0000, '0, 4'd8, 1'b1);
        send_request(msc_pkg::OP_SAMPLE, '0, '1, 4'd8, 1'b1);
        send_request(msc_pkg::OP_SAMPLE, 64'hFFFF_FFFF_3F80_0000, '0, 4'd4, 1'b0);
        send_request(msc_pkg::OP_SAMPLE, 64'h3586_37BD, '0, 4'd4, 1'b1);
        send_request(msc_pkg::OP_SAMPLE, 64'h7F80_0000, '0, 4'd4, 1'b1);
        send_request(msc_pkg::OP_SAMPLE, 64'h8000_0000, '0, 4'd4, 1'b1);
        send_request(msc_pkg::OP_SAMPLE, 64'h3FF0_0000_0000_0000, '0, 4'd8, 1'b0);
        send_request(msc_pkg::OP_SAMPLE, 64'h3F80_0000, '0, 4'd4, 1'b1);
        send_request(msc_pkg::OP_SAMPLE, '1, '1, 4'd0, 1'b1);
        send_request(msc_pkg::OP_SAMPLE, '1, '1, 4'd15, 1'b1);
        send_request(OP_IGNORED, '1, '1, 4'd15, 1'b1);
        send_request(msc_pkg::OP_SAMPLE, 64'hFF12_3456, '0, 4'd3, 1'b1);
    endtask

    task automatic test_eight_byte_pointers();
        write_pointer_width(1'b1);
        run_phase(450);
    endtask

    task automatic test_four_byte_pointers();
        write_pointer_width(1'b0);
        run_phase(450);
    endtask

    task automatic test_pointer_width_toggle();
        int i;
        for (i = 0; i < 4; i++)
        begin
            write_pointer_width(i[0]);
            run_phase(250);
        end
    endtask

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (rcv_stall > 0)
        begin
            rcv_stall--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (rcv_calm > 0)
                rcv_calm--;
            else if ($urandom_range(0, 199) == 0)
                rcv_calm = $urandom_range(50, 300);
            else
                rcv_stall = draw_gap();
        end
    end

    always @(posedge clk)
    begin : result_check
        slot_verdict_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: result with none expected: type_code %0d overflow %0b",
                         $time, m_axis_tdata[2:0], m_axis_tdata[3]);
                fail_count++;
            end
            else
            begin
                due = verdicts_due.pop_front();
                if (m_axis_tdata[2:0] !== due.kind)
                begin
                    $display("%0t: type_code expected %0d got %0d",
                             $time, due.kind, m_axis_tdata[2:0]);
                    fail_count++;
                end
                if (m_axis_tdata[3] !== due.ovf)
                begin
                    $display("%0t: region_overflow expected %0b got %0b",
                             $time, due.ovf, m_axis_tdata[3]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress, %0d results outstanding",
                         $time, verdicts_due.size());
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_eight_byte_pointers();
        test_four_byte_pointers();
        test_pointer_width_toggle();
        settle_block();
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// File: memory_slot_type_classifier_top.f
+incdir+design
design/msc_pkg.sv
design/msc_range_lookup.sv
design/memory_slot_type_classifier_top.sv
dv/tb_top.sv
